// ===== rtl/core/rgb_to_hsl_pixel_convert_unit_defines.svh =====
// Assertion macros for the RGB to HSL pixel converter.
// Depends on nothing; users supply clk and rst_n in scope.
`ifndef RGB_TO_HSL_PIXEL_CONVERT_UNIT_DEFINES_SVH
`define RGB_TO_HSL_PIXEL_CONVERT_UNIT_DEFINES_SVH

// implication checked every clock outside reset
`define RHC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define RHC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rhc_pkg.sv =====
// Shared types and constants for the RGB to HSL pixel converter.
// Used by rhc_prep, rhc_div_cell and the top level.
package rhc_pkg;

    localparam int CHAN_W  = 8;
    localparam int HUE_W   = 12;
    localparam int PCT_W   = 10;
    localparam int QUO_W   = 12;
    localparam int NUM_W   = 22;
    localparam int DEN_W   = 10;
    localparam int LANES   = 4;

    localparam int LANE_HUE   = 0;
    localparam int LANE_SAT   = 1;
    localparam int LANE_LIGHT = 2;
    localparam int LANE_OPAC  = 3;

    localparam logic [HUE_W-1:0] GREY_HUE = HUE_W'(3130);

    typedef struct packed {
        logic                               valid;
        logic                               grey;
        logic [LANES-1:0][NUM_W-1:0]        num;
        logic [LANES-1:0][DEN_W-1:0]        den;
        logic [LANES-1:0][QUO_W-1:0]        quo;
    } cell_bus_t;

endpackage

// ===== rtl/core/rhc_prep.sv =====
// Front cell: channel max/min and the four dividend/divisor pairs.
// Depends on rhc_pkg.
module rhc_prep
    import rhc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_valid,
    input  logic [CHAN_W-1:0] red,
    input  logic [CHAN_W-1:0] green,
    input  logic [CHAN_W-1:0] blue,
    input  logic [CHAN_W-1:0] transparency,
    output cell_bus_t         bus_out
);

    cell_bus_t bus_reg;
    cell_bus_t bus_next;

    logic [CHAN_W-1:0] mx;
    logic [CHAN_W-1:0] mn;
    logic [CHAN_W-1:0] d;
    logic [CHAN_W:0]   sum;
    logic [DEN_W-1:0]  sat_den;
    logic [NUM_W-1:0]  hue_num;
    logic [NUM_W-1:0]  dw;
    logic [NUM_W-1:0] rw, gw, bw;

    always_comb
    begin
        mx = red;
        if (green > mx) mx = green;
        if (blue > mx) mx = blue;
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn) mn = blue;
        d   = mx - mn;
        sum = {1'b0, mx} + {1'b0, mn};
        sat_den = (sum > 9'd255) ? (DEN_W'(510) - DEN_W'(sum)) : DEN_W'(sum);
        dw = NUM_W'(d);
        rw = NUM_W'(red);
        gw = NUM_W'(green);
        bw = NUM_W'(blue);
        if (mx == red)
        begin
            if (green >= blue)
                hue_num = NUM_W'(600) * (gw - bw);
            else
                hue_num = NUM_W'(3600) * dw - NUM_W'(600) * (bw - gw);
        end
        else if (mx == green)
            hue_num = NUM_W'(1200) * dw + NUM_W'(600) * bw - NUM_W'(600) * rw;
        else
            hue_num = NUM_W'(2400) * dw + NUM_W'(600) * rw - NUM_W'(600) * gw;

        bus_next       = '0;
        bus_next.valid = in_valid;
        bus_next.grey  = (d == '0);
        bus_next.num[LANE_HUE]   = (hue_num << 1) + dw;
        bus_next.den[LANE_HUE]   = DEN_W'(d) << 1;
        bus_next.num[LANE_SAT]   = NUM_W'(2000) * dw + NUM_W'(sat_den);
        bus_next.den[LANE_SAT]   = sat_den << 1;
        bus_next.num[LANE_LIGHT] = NUM_W'(2000) * NUM_W'(sum) + NUM_W'(510);
        bus_next.den[LANE_LIGHT] = DEN_W'(1020);
        bus_next.num[LANE_OPAC]  = NUM_W'(2000) * NUM_W'(transparency) + NUM_W'(255);
        bus_next.den[LANE_OPAC]  = DEN_W'(510);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bus_reg <= '0;
        else if (advance)
            bus_reg <= bus_next;
    end

    assign bus_out = bus_reg;

endmodule

// ===== rtl/core/rhc_div_cell.sv =====
// One cell of the divider chain: settles one quotient bit in every lane.
// Depends on rhc_pkg.
module rhc_div_cell
    import rhc_pkg::*;
#(
    parameter int BIT = QUO_W - 1
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  cell_bus_t bus_in,
    output cell_bus_t bus_out
);

    cell_bus_t        bus_reg;
    cell_bus_t        bus_next;
    logic [NUM_W-1:0] trial [LANES];

    always_comb
    begin
        bus_next = bus_in;
        for (int l = 0; l < LANES; l++)
        begin
            trial[l] = NUM_W'(bus_in.den[l]) << BIT;
            if (bus_in.num[l] >= trial[l])
            begin
                bus_next.num[l]      = bus_in.num[l] - trial[l];
                bus_next.quo[l][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bus_reg <= '0;
        else if (advance)
            bus_reg <= bus_next;
    end

    assign bus_out = bus_reg;

endmodule

// ===== rtl/core/rgb_to_hsl_pixel_convert_unit.sv =====
// Top level of the RGB to HSL pixel converter: front cell, divider chain, output register.
// Depends on rhc_pkg, rhc_prep, rhc_div_cell and the assertion macro header.
//
//  channel | handshake            | payload
//  input   | in_valid / in_ready  | red, green, blue, transparency
//  output  | out_valid / out_ready| hue, saturation, lightness, opacity_pct
//
// One pixel per cycle unless the output stalls. Registers in order: front cell, one cell
// per quotient bit (12), output register. The whole chain advances together whenever
// the output register is empty or being taken; a stall at the output holds every cell.
// Reset clears the valid flags of all cells and the output register.
`include "rgb_to_hsl_pixel_convert_unit_defines.svh"
module rgb_to_hsl_pixel_convert_unit
    import rhc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAN_W-1:0] red,
    input  logic [CHAN_W-1:0] green,
    input  logic [CHAN_W-1:0] blue,
    input  logic [CHAN_W-1:0] transparency,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [HUE_W-1:0]  hue,
    output logic [PCT_W-1:0]  saturation,
    output logic [PCT_W-1:0]  lightness,
    output logic [PCT_W-1:0]  opacity_pct
);

    logic      advance;
    cell_bus_t chain [QUO_W+1];

    logic             out_valid_reg;
    logic [HUE_W-1:0] hue_reg, hue_next;
    logic [PCT_W-1:0] sat_reg, sat_next;
    logic [PCT_W-1:0] light_reg, light_next;
    logic [PCT_W-1:0] opac_reg, opac_next;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    rhc_prep u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .in_valid     (in_valid),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .transparency (transparency),
        .bus_out      (chain[0])
    );

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_cell
        rhc_div_cell #(
            .BIT (QUO_W - 1 - k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .bus_in  (chain[k]),
            .bus_out (chain[k+1])
        );
    end

    always_comb
    begin
        hue_next   = chain[QUO_W].grey ? GREY_HUE : HUE_W'(chain[QUO_W].quo[LANE_HUE]);
        sat_next   = chain[QUO_W].grey ? '0 : PCT_W'(chain[QUO_W].quo[LANE_SAT]);
        light_next = PCT_W'(chain[QUO_W].quo[LANE_LIGHT]);
        opac_next  = PCT_W'(chain[QUO_W].quo[LANE_OPAC]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= chain[QUO_W].valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            light_reg <= light_next;
            opac_reg  <= opac_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hue         = hue_reg;
    assign saturation  = sat_reg;
    assign lightness   = light_reg;
    assign opacity_pct = opac_reg;

    `RHC_ASSERT_IMP(a_hue_range, out_valid, hue < HUE_W'(3600), "hue out of range")
    `RHC_ASSERT_IMP(a_sat_range, out_valid, saturation <= PCT_W'(1000), "saturation range")
    `RHC_ASSERT_IMP(a_light_range, out_valid, lightness <= PCT_W'(1000), "lightness range")
    `RHC_ASSERT_IMP(a_opac_range, out_valid, opacity_pct <= PCT_W'(1000), "opacity range")
    `RHC_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, $stable(chain[QUO_W].valid), "no hold")

endmodule

// ===== test/rgb_to_hsl_pixel_convert_checker.sv =====
// Checker for the RGB to HSL pixel converter: watches both channels, predicts
// each pixel's hue, saturation, lightness and opacity, and counts mismatches.
// Depends on rhc_pkg for field widths.
`timescale 1ns / 1ps
module rgb_to_hsl_pixel_convert_checker
    import rhc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [CHAN_W-1:0] red,
    input  logic [CHAN_W-1:0] green,
    input  logic [CHAN_W-1:0] blue,
    input  logic [CHAN_W-1:0] transparency,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [HUE_W-1:0]  hue,
    input  logic [PCT_W-1:0]  saturation,
    input  logic [PCT_W-1:0]  lightness,
    input  logic [PCT_W-1:0]  opacity_pct,
    output int                fail_count,
    output int                pending_count
);

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] light;
        logic [PCT_W-1:0] opac;
    } hsl_t;

    hsl_t hsl_queue[$];

    function automatic int unsigned div_half_up(int unsigned num, int unsigned den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic hsl_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                           logic [7:0] t);
        int unsigned mx, mn, d, s, den, h;
        hsl_t res;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        s = mx + mn;
        res.light = PCT_W'(div_half_up(s * 1000, 510));
        res.opac  = PCT_W'(div_half_up(t * 1000, 255));
        if (d == 0) begin
            res.hue = GREY_HUE;
            res.sat = '0;
        end
        else begin
            den = (s > 255) ? (510 - s) : s;
            res.sat = PCT_W'(div_half_up(d * 1000, den));
            if (mx == r) begin
                if (g >= b)
                    h = div_half_up(600 * (g - b), d);
                else
                    h = div_half_up(3600 * d - 600 * (b - g), d);
            end
            else if (mx == g)
                h = div_half_up(1200 * d + 600 * b - 600 * r, d);
            else
                h = div_half_up(2400 * d + 600 * r - 600 * g, d);
            res.hue = HUE_W'(h);
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;
    assign pending_count = hsl_queue.size();

    always @(posedge clk) begin
        hsl_t want;
        if (rst_n) begin
            if (in_valid && in_ready)
                hsl_queue.push_back(convert_pixel(red, green, blue, transparency));
            if (out_valid && out_ready) begin
                if (hsl_queue.size() == 0)
                    report_mismatch("unexpected result", 1, 0);
                else begin
                    want = hsl_queue.pop_front();
                    if (hue != want.hue) report_mismatch("hue", hue, want.hue);
                    if (saturation != want.sat)
                        report_mismatch("saturation", saturation, want.sat);
                    if (lightness != want.light)
                        report_mismatch("lightness", lightness, want.light);
                    if (opacity_pct != want.opac)
                        report_mismatch("opacity_pct", opacity_pct, want.opac);
                end
            end
        end
    end

endmodule

// ===== test/tb.sv =====
// Testbench top for the RGB to HSL pixel converter: drives directed and random
// pixels under several idle patterns. Depends on rhc_pkg, the block and the checker.
`timescale 1ns / 1ps
module tb;
    import rhc_pkg::*;

    localparam int LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [CHAN_W-1:0] red = '0, green = '0, blue = '0, transparency = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] saturation, lightness, opacity_pct;
    int fail_count, pending_count;
    int send_idle_pct = 0, recv_stall_pct = 0;
    int hold_off = 0;
    logic long_stall = 1'b0;
    logic long_stall_done = 1'b0;
    int cycle_count = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    rgb_to_hsl_pixel_convert_unit u_dut (.*);

    rgb_to_hsl_pixel_convert_checker u_chk (.*);

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (long_stall && !long_stall_done) begin
            out_ready <= 1'b0;
            hold_off <= 80;
            long_stall_done <= 1'b1;
        end
        else if (hold_off > 0) begin
            out_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        red <= r;
        green <= g;
        blue <= b;
        transparency <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_random_pixel();
        logic [7:0] r, g, b, m;
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        m = 8'($urandom);
        case ($urandom_range(5))
            0: g = r;
            1: b = g;
            2: begin g = r; b = r; end
            3: begin r = m; g = m - 8'($urandom_range(3)); end
            default: ;
        endcase
        send_pixel(r, g, b, 8'($urandom));
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_pixel(0, 0, 0, 0);
        send_pixel(255, 255, 255, 255);
        send_pixel(128, 128, 128, 1);
        send_pixel(255, 0, 0, 254);
        send_pixel(0, 255, 0, 127);
        send_pixel(0, 0, 255, 128);
        send_pixel(255, 0, 1, 85);
        send_pixel(255, 255, 0, 170);
        send_pixel(255, 0, 255, 51);
        send_pixel(0, 255, 255, 204);
        send_pixel(200, 200, 10, 3);
        send_pixel(10, 200, 200, 252);
        send_pixel(128, 127, 0, 100);
        send_pixel(127, 128, 0, 170);
        send_pixel(1, 0, 0, 0);
        send_pixel(255, 254, 254, 255);
        send_pixel(170, 85, 85, 2);
        send_pixel(85, 170, 170, 253);
        send_pixel(0, 1, 255, 200);
        send_pixel(255, 128, 0, 60);
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 45 : 17) : 0;
            recv_stall_pct = (ph == 2) ? 45 : (ph == 3) ? 17 : 0;
            if (ph == 2) long_stall = 1'b1;
            for (int i = 0; i < 408; i++) send_random_pixel();
        end
        in_valid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (pending_count != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/rhc_pkg.sv
rtl/core/rhc_prep.sv
rtl/core/rhc_div_cell.sv
rtl/core/rgb_to_hsl_pixel_convert_unit.sv
test/rgb_to_hsl_pixel_convert_checker.sv
test/tb.sv
